/* sv/lpq2d_pkg.sv */
package lpq2d_pkg;

	// Default field widths.
	localparam int COORD_WIDTH_DEF = 40;
	localparam int CODE_WIDTH_DEF = 32;

	// Error bound register.
	localparam int BOUND_WIDTH = 32;
	localparam logic [BOUND_WIDTH-1:0] ERROR_BOUND_RESET = 32'd15185;

	// Configuration port: one 32-bit register per word.
	localparam int PDATA_WIDTH = 32;
	localparam int PADDR_WIDTH = 3;
	localparam int REG_IDX_WIDTH = PADDR_WIDTH - 2;
	localparam logic [REG_IDX_WIDTH-1:0] REG_ERROR_BOUND = 1'b0;

	// The first point is predicted as 2.0 degrees, that is 2^32 LSBs.
	localparam int TWO_DEGREES_LOG2 = 32;
	localparam logic [63:0] TWO_DEGREES = 64'd1 << TWO_DEGREES_LOG2;

	// Predictor phase, from the number of points seen since reset.
	localparam int PHASE_WIDTH = 2;
	localparam logic [PHASE_WIDTH-1:0] PHASE_FIRST = 2'd0;
	localparam logic [PHASE_WIDTH-1:0] PHASE_SECOND = 2'd1;
	localparam logic [PHASE_WIDTH-1:0] PHASE_LINEAR = 2'd2;

	// Commands from the controller to the datapath, one per step of an item.
	typedef struct packed {
		logic load;
		logic pred;
		logic res;
		logic mag;
		logic num;
		logic div;
		logic sat;
		logic step;
		logic sum;
		logic fin;
	} lpq2d_cmd_t;

	// Width of the divider dividend, which is also its number of iterations.
	// The dividend is |residual| + bound, below 2^(coord_width+1) + 2^32.
	function automatic int div_steps(input int coord_width);
		int w;
		w = (coord_width + 2 > BOUND_WIDTH + 1) ? coord_width + 2 : BOUND_WIDTH + 1;
		return w + 1;
	endfunction

endpackage

/* sv/lpq2d_axis.sv */
module lpq2d_axis
	import lpq2d_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int CODE_WIDTH = CODE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lpq2d_cmd_t                    cmd,
	input  logic [PHASE_WIDTH-1:0]        phase,
	input  logic [BOUND_WIDTH-1:0]        bound,
	input  logic signed [COORD_WIDTH-1:0] coord,
	output logic                          in_bound,
	output logic [CODE_WIDTH-1:0]         code,
	output logic signed [COORD_WIDTH-1:0] recon
);

	localparam int PW = COORD_WIDTH + 2;
	localparam int RW = COORD_WIDTH + 3;
	localparam int NW = div_steps(COORD_WIDTH);
	localparam int DW = BOUND_WIDTH + 1;
	localparam int SW = ((NW > BOUND_WIDTH + CODE_WIDTH + 1) ? NW :
		BOUND_WIDTH + CODE_WIDTH + 1) + 1;
	localparam int AW = SW + 2;
	localparam int MW = ((NW > CODE_WIDTH) ? NW : CODE_WIDTH) + 1;

	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic signed [COORD_WIDTH-1:0] FIRST_PRED =
		(COORD_WIDTH > TWO_DEGREES_LOG2 + 1) ? COORD_WIDTH'(TWO_DEGREES) : COORD_MAX;

	logic signed [COORD_WIDTH-1:0] x_q;
	logic signed [COORD_WIDTH-1:0] last_q;
	logic signed [COORD_WIDTH-1:0] prev_q;
	logic signed [PW-1:0]          pred_q;
	logic signed [RW-1:0]          res_q;
	logic [RW-1:0]                 mag_q;
	logic                          neg_q;
	logic                          within_q;
	logic [NW-1:0]                 num_q;
	logic [NW-1:0]                 keep_q;
	logic [DW-1:0]                 rem_q;
	logic                          sat_q;
	logic [CODE_WIDTH-1:0]         code_q;
	logic [SW-1:0]                 step_q;
	logic signed [AW-1:0]          sum_q;

	logic signed [PW-1:0]  pred_lin;
	logic signed [PW-1:0]  pred_d;
	logic [DW-1:0]         divisor;
	logic [DW:0]           trial;
	logic                  ge;
	logic [NW-1:0]         num_d;
	logic [MW-1:0]         q_ext;
	logic [MW-1:0]         half;
	logic [MW-1:0]         lim;
	logic                  sat_d;
	logic [CODE_WIDTH-1:0] qm_d;
	logic [SW-1:0]         step_d;
	logic signed [AW-1:0]  step_s;

	// Prediction from the reconstructed history.
	assign pred_lin = PW'(last_q) + PW'(last_q) - PW'(prev_q);

	always_comb begin
		case (phase)
			PHASE_FIRST:  pred_d = PW'(FIRST_PRED);
			PHASE_SECOND: pred_d = PW'(last_q);
			default:      pred_d = pred_lin;
		endcase
	end

	// One restoring division step by twice the bound.
	assign divisor = {bound, 1'b0};
	assign trial = {rem_q, num_q[NW-1]};
	assign ge = trial >= {1'b0, divisor};
	assign num_d = NW'(mag_q) + NW'(bound);

	// Saturation of the quotient to the code range.
	assign q_ext = MW'(num_q);
	assign half = MW'(1) << (CODE_WIDTH - 1);
	assign lim = neg_q ? half : half - MW'(1);
	assign sat_d = q_ext > lim;
	assign qm_d = sat_d ? CODE_WIDTH'(lim) : CODE_WIDTH'(num_q);

	// The step is quotient times divisor: dividend minus remainder when the
	// quotient is kept, and a shifted bound when it saturates.
	always_comb begin
		if (sat_q) begin
			step_d = (SW'(bound) << CODE_WIDTH) - (neg_q ? SW'(0) : SW'(divisor));
		end else begin
			step_d = SW'(keep_q) - SW'(rem_q);
		end
	end

	assign step_s = $signed(AW'(step_q));

	// Working registers, each loaded by its own command.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= coord;
		end
		if (cmd.pred) begin
			pred_q <= pred_d;
		end
		if (cmd.res) begin
			res_q <= RW'(x_q) - RW'(pred_q);
		end
		if (cmd.mag) begin
			neg_q <= res_q[RW-1];
			mag_q <= res_q[RW-1] ? RW'(-res_q) : RW'(res_q);
		end
		if (cmd.num) begin
			num_q <= num_d;
			keep_q <= num_d;
			rem_q <= '0;
			within_q <= NW'(mag_q) <= NW'(bound);
		end else if (cmd.div) begin
			num_q <= {num_q[NW-2:0], ge};
			rem_q <= ge ? DW'(trial - {1'b0, divisor}) : DW'(trial);
		end
		if (cmd.sat) begin
			sat_q <= sat_d;
			code_q <= neg_q ? CODE_WIDTH'(-qm_d) : qm_d;
		end
		if (cmd.step) begin
			step_q <= step_d;
		end
		if (cmd.sum) begin
			sum_q <= neg_q ? AW'(pred_q) - step_s : AW'(pred_q) + step_s;
		end
	end

	// Reconstruction clipped to the coordinate range.
	always_comb begin
		if (sum_q > AW'(COORD_MAX)) begin
			recon = COORD_MAX;
		end else if (sum_q < AW'(COORD_MIN)) begin
			recon = COORD_MIN;
		end else begin
			recon = COORD_WIDTH'(sum_q);
		end
	end

	// History of reconstructions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			prev_q <= '0;
		end else if (cmd.fin) begin
			prev_q <= last_q;
			last_q <= recon;
		end
	end

	assign in_bound = within_q;
	assign code = code_q;

endmodule

/* sv/lpq2d_dp.sv */
module lpq2d_dp
	import lpq2d_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int CODE_WIDTH = CODE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lpq2d_cmd_t                    cmd,
	input  logic [BOUND_WIDTH-1:0]        error_bound,
	input  logic signed [COORD_WIDTH-1:0] longitude,
	input  logic signed [COORD_WIDTH-1:0] latitude,
	output logic                          accurate,
	output logic                          warm_up,
	output logic signed [CODE_WIDTH-1:0]  lon_code,
	output logic signed [CODE_WIDTH-1:0]  lat_code,
	output logic signed [COORD_WIDTH-1:0] lon_recon,
	output logic signed [COORD_WIDTH-1:0] lat_recon
);

	logic [BOUND_WIDTH-1:0]        bound_q;
	logic [PHASE_WIDTH-1:0]        points_q;
	logic                          lon_within;
	logic                          lat_within;
	logic [CODE_WIDTH-1:0]         lon_code_w;
	logic [CODE_WIDTH-1:0]         lat_code_w;
	logic signed [COORD_WIDTH-1:0] lon_recon_w;
	logic signed [COORD_WIDTH-1:0] lat_recon_w;

	// The bound is held for the whole item; a zero bound acts as one.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bound_q <= (error_bound == '0) ? BOUND_WIDTH'(1) : error_bound;
		end
	end

	lpq2d_axis #(
		.COORD_WIDTH(COORD_WIDTH),
		.CODE_WIDTH (CODE_WIDTH)
	) u_lon (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.phase   (points_q),
		.bound   (bound_q),
		.coord   (longitude),
		.in_bound(lon_within),
		.code    (lon_code_w),
		.recon   (lon_recon_w)
	);

	lpq2d_axis #(
		.COORD_WIDTH(COORD_WIDTH),
		.CODE_WIDTH (CODE_WIDTH)
	) u_lat (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.phase   (points_q),
		.bound   (bound_q),
		.coord   (latitude),
		.in_bound(lat_within),
		.code    (lat_code_w),
		.recon   (lat_recon_w)
	);

	// Points seen since reset, saturating once linear prediction starts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= PHASE_FIRST;
		end else if (cmd.fin && points_q != PHASE_LINEAR) begin
			points_q <= points_q + PHASE_WIDTH'(1);
		end
	end

	// Result register, held until the next item finishes.
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			accurate <= (points_q == PHASE_LINEAR) && lon_within && lat_within;
			warm_up <= points_q != PHASE_LINEAR;
			lon_code <= lon_code_w;
			lat_code <= lat_code_w;
			lon_recon <= lon_recon_w;
			lat_recon <= lat_recon_w;
		end
	end

endmodule

/* sv/lpq2d_ctrl.sv */
module lpq2d_ctrl
	import lpq2d_pkg::*;
#(
	parameter int DIV_STEPS = div_steps(COORD_WIDTH_DEF)
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pt_valid,
	output logic       pt_stall,
	output logic       res_valid,
	input  logic       res_stall,
	output lpq2d_cmd_t cmd
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PRED = 4'd1;
	localparam logic [3:0] S_RES  = 4'd2;
	localparam logic [3:0] S_MAG  = 4'd3;
	localparam logic [3:0] S_NUM  = 4'd4;
	localparam logic [3:0] S_DIV  = 4'd5;
	localparam logic [3:0] S_SAT  = 4'd6;
	localparam logic [3:0] S_STEP = 4'd7;
	localparam logic [3:0] S_SUM  = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	logic [3:0]       state_q;
	logic [3:0]       state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             res_valid_q;
	logic             out_free;

	assign out_free = !res_valid_q || !res_stall;

	// Sequencing of one item and the commands of each step.
	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (pt_valid) begin
					cmd.load = 1'b1;
					state_d = S_PRED;
				end
			end
			S_PRED: begin
				cmd.pred = 1'b1;
				state_d = S_RES;
			end
			S_RES: begin
				cmd.res = 1'b1;
				state_d = S_MAG;
			end
			S_MAG: begin
				cmd.mag = 1'b1;
				state_d = S_NUM;
			end
			S_NUM: begin
				cmd.num = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (cnt_q == '0) begin
					state_d = S_SAT;
				end
			end
			S_SAT: begin
				cmd.sat = 1'b1;
				state_d = S_STEP;
			end
			S_STEP: begin
				cmd.step = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, divider iteration count and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.num) begin
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end else if (cmd.div) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.fin) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign pt_stall = state_q != S_IDLE;
	assign res_valid = res_valid_q;

endmodule

/* sv/linear_predictive_quantizer_2d_core.sv */
// An accepted item goes through the prediction, residual, magnitude, divider,
// saturation, step, sum and finish states before its result is registered.
// A new item is taken only once the last one has finished; the bit-serial
// divider does one quotient bit per cycle, and a stalled result holds finish.
// Reset clears the history, the point count and the result valid flag and
// loads the error bound with 15185.
module linear_predictive_quantizer_2d_core
	import lpq2d_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int CODE_WIDTH = CODE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [PADDR_WIDTH-1:0]        paddr,
	input  logic [PDATA_WIDTH-1:0]        pwdata,
	output logic [PDATA_WIDTH-1:0]        prdata,
	output logic                          pready,
	input  logic                          pt_valid,
	output logic                          pt_stall,
	input  logic signed [COORD_WIDTH-1:0] longitude,
	input  logic signed [COORD_WIDTH-1:0] latitude,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          accurate,
	output logic                          warm_up,
	output logic signed [CODE_WIDTH-1:0]  lon_code,
	output logic signed [CODE_WIDTH-1:0]  lat_code,
	output logic signed [COORD_WIDTH-1:0] lon_recon,
	output logic signed [COORD_WIDTH-1:0] lat_recon
);

	logic [BOUND_WIDTH-1:0] error_bound_q;
	logic                   bound_sel;
	lpq2d_cmd_t             cmd;

	// Register file access: the error bound is the only register.
	assign pready = 1'b1;
	assign bound_sel = paddr[PADDR_WIDTH-1:2] == REG_ERROR_BOUND;
	assign prdata = bound_sel ? PDATA_WIDTH'(error_bound_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_bound_q <= ERROR_BOUND_RESET;
		end else if (psel && penable && pwrite && pready && bound_sel) begin
			error_bound_q <= BOUND_WIDTH'(pwdata);
		end
	end

	lpq2d_ctrl #(
		.DIV_STEPS(div_steps(COORD_WIDTH))
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt_valid (pt_valid),
		.pt_stall (pt_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.cmd      (cmd)
	);

	lpq2d_dp #(
		.COORD_WIDTH(COORD_WIDTH),
		.CODE_WIDTH (CODE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.error_bound(error_bound_q),
		.longitude  (longitude),
		.latitude   (latitude),
		.accurate   (accurate),
		.warm_up    (warm_up),
		.lon_code   (lon_code),
		.lat_code   (lat_code),
		.lon_recon  (lon_recon),
		.lat_recon  (lat_recon)
	);

endmodule

/* tb/linear_predictive_quantizer_2d_core_test.sv */
module linear_predictive_quantizer_2d_core_test;
	import lpq2d_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int QW = CODE_WIDTH_DEF;
	localparam int ITEM_LATENCY = div_steps(COORD_WIDTH_DEF) + 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD = 600;
	localparam int RANDOM_PHASES = 8;
	localparam int HOLD_PHASE = 3;
	localparam logic [PADDR_WIDTH-1:0] ADDR_ERROR_BOUND = {REG_ERROR_BOUND, 2'b00};

	typedef logic signed [127:0] wide_t;
	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [QW-1:0] code_t;

	localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam code_t CODE_MAX = {1'b0, {(QW-1){1'b1}}};
	localparam code_t CODE_MIN = {1'b1, {(QW-1){1'b0}}};
	localparam coord_t TWO_DEG = coord_t'(TWO_DEGREES);

	typedef struct packed {
		logic accurate;
		logic warm_up;
		code_t lon_code;
		code_t lat_code;
		coord_t lon_recon;
		coord_t lat_recon;
	} point_result_t;

	typedef struct packed {
		logic set_bound;
		logic [BOUND_WIDTH-1:0] bound;
		coord_t lon;
		coord_t lat;
		logic typed;
		point_result_t want;
	} stim_row_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_WIDTH-1:0] paddr = '0;
	logic [PDATA_WIDTH-1:0] pwdata = '0;
	logic [PDATA_WIDTH-1:0] prdata;
	logic pready;
	logic pt_valid = 1'b0;
	logic pt_stall;
	coord_t longitude = '0;
	coord_t latitude = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic accurate;
	logic warm_up;
	code_t lon_code;
	code_t lat_code;
	coord_t lon_recon;
	coord_t lat_recon;

	// Mirror of the quantizer state.
	logic [BOUND_WIDTH-1:0] bound_reg = ERROR_BOUND_RESET;
	coord_t last_lon = '0;
	coord_t prev_lon = '0;
	coord_t last_lat = '0;
	coord_t prev_lat = '0;
	int points_taken = 0;

	point_result_t expected_results[$];
	stim_row_t directed_rows[$];
	int fail_count = 0;
	int cycle_count = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int mode_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int burst_left = 0;
	coord_t track_lon, track_lat;
	longint vel_lon, vel_lat;
	point_result_t seen_result;

	linear_predictive_quantizer_2d_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.pt_valid(pt_valid),
		.pt_stall(pt_stall),
		.longitude(longitude),
		.latitude(latitude),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.accurate(accurate),
		.warm_up(warm_up),
		.lon_code(lon_code),
		.lat_code(lat_code),
		.lon_recon(lon_recon),
		.lat_recon(lat_recon)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Saturate an exact value to the signed coordinate range.
	function automatic coord_t clip_to_coord(wide_t v);
		wide_t top;
		wide_t bottom;
		top = (wide_t'(1) <<< (CW - 1)) - 1;
		bottom = -top - 1;
		if (v > top) v = top;
		if (v < bottom) v = bottom;
		return v[CW-1:0];
	endfunction

	// Quantize one axis against its prediction from the reconstructed history.
	task automatic quantize_axis(input coord_t x, input coord_t last, input coord_t prev,
			input logic [PHASE_WIDTH-1:0] phase, input wide_t bound,
			output logic in_bound, output code_t code, output coord_t recon);
		wide_t pred, resid, mag, quo, limit, qsat, offset;
		logic neg;
		case (phase)
			PHASE_FIRST: pred = clip_to_coord(wide_t'(TWO_DEGREES));
			PHASE_SECOND: pred = wide_t'(last);
			default: pred = 2 * wide_t'(last) - wide_t'(prev);
		endcase
		resid = wide_t'(x) - pred;
		neg = resid < 0;
		mag = neg ? -resid : resid;
		in_bound = mag <= bound;
		// Round half away from zero on the magnitude.
		quo = (mag + bound) / (2 * bound);
		limit = (wide_t'(1) <<< (QW - 1)) - (neg ? 0 : 1);
		qsat = (quo > limit) ? limit : quo;
		code = code_t'(neg ? -qsat : qsat);
		offset = 2 * bound * qsat;
		recon = clip_to_coord(neg ? pred - offset : pred + offset);
	endtask

	// Work out the result of one point and advance the mirrored history.
	task automatic predict_point(input coord_t lon, input coord_t lat,
			output point_result_t res);
		wide_t bound;
		logic [PHASE_WIDTH-1:0] phase;
		logic lon_ok, lat_ok;
		code_t c_lon, c_lat;
		coord_t r_lon, r_lat;
		bound = (bound_reg == 0) ? wide_t'(1) : wide_t'(bound_reg);
		phase = (points_taken == 0) ? PHASE_FIRST :
			(points_taken == 1) ? PHASE_SECOND : PHASE_LINEAR;
		quantize_axis(lon, last_lon, prev_lon, phase, bound, lon_ok, c_lon, r_lon);
		quantize_axis(lat, last_lat, prev_lat, phase, bound, lat_ok, c_lat, r_lat);
		res.accurate = (phase == PHASE_LINEAR) && lon_ok && lat_ok;
		res.warm_up = (phase != PHASE_LINEAR);
		res.lon_code = c_lon;
		res.lat_code = c_lat;
		res.lon_recon = r_lon;
		res.lat_recon = r_lat;
		prev_lon = last_lon;
		last_lon = r_lon;
		prev_lat = last_lat;
		last_lat = r_lat;
		if (points_taken < 2) points_taken++;
	endtask

	task automatic report_field(input string field, input logic signed [63:0] want,
			input logic signed [63:0] got);
		fail_count++;
		$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
	endtask

	task automatic compare_result(input point_result_t got, input point_result_t want);
		if (got.accurate !== want.accurate) report_field("accurate", want.accurate, got.accurate);
		if (got.warm_up !== want.warm_up) report_field("warm_up", want.warm_up, got.warm_up);
		if (got.lon_code !== want.lon_code) report_field("lon_code", want.lon_code, got.lon_code);
		if (got.lat_code !== want.lat_code) report_field("lat_code", want.lat_code, got.lat_code);
		if (got.lon_recon !== want.lon_recon)
			report_field("lon_recon", want.lon_recon, got.lon_recon);
		if (got.lat_recon !== want.lat_recon)
			report_field("lat_recon", want.lat_recon, got.lat_recon);
	endtask

	// One register access: setup cycle, then access cycle until pready.
	task automatic apb_access(input logic write, input logic [PDATA_WIDTH-1:0] wdata,
			output logic [PDATA_WIDTH-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= ADDR_ERROR_BOUND;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_error_bound(input logic [BOUND_WIDTH-1:0] value);
		logic [PDATA_WIDTH-1:0] rdata;
		apb_access(1'b1, value, rdata);
		apb_access(1'b0, '0, rdata);
		if (rdata !== value) report_field("error_bound", value, rdata);
		bound_reg = value;
	endtask

	// Offer one point and hold it until the block takes it.
	task automatic offer_point(input coord_t lon, input coord_t lat, input logic typed,
			input point_result_t typed_result);
		point_result_t predicted;
		pt_valid <= 1'b1;
		longitude <= lon;
		latitude <= lat;
		do @(posedge clk); while (pt_stall);
		predict_point(lon, lat, predicted);
		expected_results.insert(expected_results.size(), typed ? typed_result : predicted);
	endtask

	// Bursts of back-to-back points separated by random idle stretches, none when steady.
	task automatic pace_sender(input logic steady);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
			if (gap > 0) begin
				pt_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain_results();
		pt_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic add_row(input logic set_bound, input logic [BOUND_WIDTH-1:0] bound,
			input coord_t lon, input coord_t lat, input logic typed,
			input point_result_t want);
		stim_row_t row;
		row.set_bound = set_bound;
		row.bound = bound;
		row.lon = lon;
		row.lat = lat;
		row.typed = typed;
		row.want = want;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	// Uniform value in [-amp, amp].
	function automatic longint spread(longint amp);
		logic [63:0] r;
		r = {$urandom, $urandom};
		return longint'(r % (2 * amp + 1)) - amp;
	endfunction

	function automatic coord_t pick_extreme();
		case ($urandom_range(0, 3))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return coord_t'(0);
			default: return coord_t'(-1);
		endcase
	endfunction

	// Mostly a smooth track with noise around the bound, some raw and extreme points.
	task automatic next_point(output coord_t lon, output coord_t lat);
		longint b;
		int pick;
		b = (bound_reg == 0) ? longint'(1) : longint'(bound_reg);
		pick = $urandom_range(0, 99);
		vel_lon = vel_lon + spread(b / 2);
		vel_lat = vel_lat + spread(b / 2);
		track_lon = track_lon + coord_t'(vel_lon);
		track_lat = track_lat + coord_t'(vel_lat);
		if (pick < 80) begin
			lon = track_lon + coord_t'(spread(2 * b));
			lat = track_lat + coord_t'(spread(2 * b));
		end else if (pick < 90) begin
			lon = coord_t'({$urandom, $urandom});
			lat = coord_t'({$urandom, $urandom});
		end else begin
			lon = pick_extreme();
			lat = pick_extreme();
		end
	endtask

	// Cycle limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result checker and receiver stall pattern.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			seen_result = {accurate, warm_up, lon_code, lat_code, lon_recon, lat_recon};
			if (expected_results.size() == 0) begin
				fail_count++;
				$display("%0t: expected no result, got lon_recon %0d lat_recon %0d",
					$time, lon_recon, lat_recon);
			end else begin
				compare_result(seen_result, expected_results.pop_front());
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (holds_served != hold_requests) begin
			holds_served++;
			hold_left = LONG_HOLD;
			res_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(1, 200);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				STALL_NONE: res_stall <= 1'b0;
				STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
				default: res_stall <= ~res_stall;
			endcase
		end
	end

	// Stimulus.
	initial begin
		logic [PDATA_WIDTH-1:0] rdata;
		logic [BOUND_WIDTH-1:0] phase_bound;
		coord_t lon, lat;
		int count;

		// Points at two degrees first: zero residual on every predictor.
		add_row(1'b0, 0, TWO_DEG, TWO_DEG, 1'b1,
			{1'b0, 1'b1, code_t'(0), code_t'(0), TWO_DEG, TWO_DEG});
		add_row(1'b0, 0, TWO_DEG, TWO_DEG, 1'b1,
			{1'b0, 1'b1, code_t'(0), code_t'(0), TWO_DEG, TWO_DEG});
		add_row(1'b0, 0, TWO_DEG, TWO_DEG, 1'b1,
			{1'b1, 1'b0, code_t'(0), code_t'(0), TWO_DEG, TWO_DEG});
		// A zero bound acts as one, so both codes saturate.
		add_row(1'b1, 0, COORD_MAX, COORD_MIN, 1'b1, {1'b0, 1'b0, CODE_MAX, CODE_MIN,
			coord_t'(2 * TWO_DEGREES - 2), coord_t'(0)});
		add_row(1'b0, 0, COORD_MIN, COORD_MAX, 1'b0, '0);
		add_row(1'b0, 0, coord_t'(0), coord_t'(0), 1'b0, '0);
		// Largest bound: far swings make the extrapolation leave the range.
		add_row(1'b1, '1, COORD_MAX, COORD_MIN, 1'b0, '0);
		add_row(1'b0, 0, COORD_MIN, COORD_MAX, 1'b0, '0);
		add_row(1'b0, 0, COORD_MAX, COORD_MAX, 1'b0, '0);
		add_row(1'b0, 0, COORD_MIN, COORD_MIN, 1'b0, '0);
		// Unit bound around zero gives exact ties.
		add_row(1'b1, 1, coord_t'(-1), coord_t'(1), 1'b0, '0);
		add_row(1'b0, 0, coord_t'(0), coord_t'(0), 1'b0, '0);
		add_row(1'b0, 0, coord_t'(1), coord_t'(-1), 1'b0, '0);
		add_row(1'b1, ERROR_BOUND_RESET, coord_t'(15185), coord_t'(-15185), 1'b0, '0);
		add_row(1'b0, 0, coord_t'(30370), coord_t'(-30370), 1'b0, '0);
		add_row(1'b0, 0, coord_t'(45555), coord_t'(45555), 1'b0, '0);
		add_row(1'b1, 32'h8000_0000, COORD_MAX, coord_t'(0), 1'b0, '0);
		add_row(1'b0, 0, coord_t'(0), COORD_MIN, 1'b0, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_access(1'b0, '0, rdata);
		if (rdata !== ERROR_BOUND_RESET) report_field("error_bound", ERROR_BOUND_RESET, rdata);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].set_bound) begin
				drain_results();
				set_error_bound(directed_rows[i].bound);
			end
			offer_point(directed_rows[i].lon, directed_rows[i].lat, directed_rows[i].typed,
				directed_rows[i].want);
			pace_sender(1'b0);
		end

		// Random phases, each with its own bound and a fresh track.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_results();
			case (p)
				0: phase_bound = ERROR_BOUND_RESET;
				1: phase_bound = 1;
				2: phase_bound = $urandom_range(2, 64);
				3: phase_bound = $urandom_range(100, 100000);
				4: phase_bound = '1;
				5: phase_bound = 0;
				6: phase_bound = $urandom;
				default: phase_bound = $urandom_range(1000, 1 << 20);
			endcase
			set_error_bound(phase_bound);
			track_lon = coord_t'({$urandom, $urandom}) >>> 2;
			track_lat = coord_t'({$urandom, $urandom}) >>> 2;
			vel_lon = spread(longint'(1) << 24);
			vel_lat = spread(longint'(1) << 24);
			// The receiver holds off for a long stretch while points keep coming.
			if (p == HOLD_PHASE) hold_requests++;
			count = $urandom_range(90, 110);
			for (int k = 0; k < count; k++) begin
				next_point(lon, lat);
				offer_point(lon, lat, 1'b0, '0);
				if (p != HOLD_PHASE && $urandom_range(0, 63) == 0) drain_results();
				else pace_sender(p == HOLD_PHASE);
			end
		end

		drain_results();
		repeat (ITEM_LATENCY + 10) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
